// File: rtl/ptq_pkg.sv
// Package: shared constants, codes and types of the priority task queue.
`timescale 1ns / 1ps
package ptq_pkg;

  localparam int DEF_QUEUE_DEPTH = 16;
  localparam int DEF_ID_BITS     = 16;
  localparam int DEF_PRI_BITS    = 8;

  localparam int OPCODE_W = 3;
  localparam int STATUS_W = 2;

  typedef enum logic [OPCODE_W-1:0] {
    OP_ADD        = 3'd0,
    OP_CANCEL_ID  = 3'd1,
    OP_CANCEL_ALL = 3'd2,
    OP_EXTRACT    = 3'd3,
    OP_FINISH     = 3'd4
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_RESP
  } state_e;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    logic add;
    logic cancel;
    logic clear;
    logic shift;
  } cell_cmd_t;

endpackage

// File: rtl/ptq_in_if.sv
// Interface: request channel of the priority task queue.
`timescale 1ns / 1ps
interface ptq_in_if #(
  parameter int ID_BITS       = ptq_pkg::DEF_ID_BITS,
  parameter int PRIORITY_BITS = ptq_pkg::DEF_PRI_BITS
);
  import ptq_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [OPCODE_W-1:0]      opcode;
  logic [ID_BITS-1:0]       task_id;
  logic [PRIORITY_BITS-1:0] task_priority;

  modport source (output valid, opcode, task_id, task_priority, input ready);
  modport sink   (input valid, opcode, task_id, task_priority, output ready);
endinterface

// File: rtl/ptq_out_if.sv
// Interface: result channel of the priority task queue.
`timescale 1ns / 1ps
interface ptq_out_if #(
  parameter int ID_BITS       = ptq_pkg::DEF_ID_BITS,
  parameter int PRIORITY_BITS = ptq_pkg::DEF_PRI_BITS,
  parameter int SIZE_BITS     = $clog2(ptq_pkg::DEF_QUEUE_DEPTH + 2)
);
  import ptq_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [STATUS_W-1:0]      status;
  logic [ID_BITS-1:0]       out_id;
  logic [PRIORITY_BITS-1:0] out_priority;
  logic                     out_cancelled;
  logic [SIZE_BITS-1:0]     size_now;

  modport source (output valid, status, out_id, out_priority, out_cancelled, size_now,
                  input ready);
  modport sink   (input valid, status, out_id, out_priority, out_cancelled, size_now,
                  output ready);
endinterface

// File: rtl/priority_task_queue_with_cancel.sv
// Top level: priority task queue with cancel marks, built as a chain of cells.
// Usage:
//   in_i  carries one request item per handshake (valid & ready): opcode,
//         task_id, task_priority. Opcodes: add, cancel by id, cancel all,
//         extract next, finish current; codes 5..7 are no-ops.
//   out_o returns exactly one result item per request, in request order:
//         status, extracted id/priority/cancel mark, and the size after the op.
// Sequence:
//   Add, cancel, cancel all, finish, no-op and extract on an empty queue go
//   from acceptance straight to the response state, which stages the result.
//   Extract on a non-empty queue first runs a search wave that
//   walks the cell chain one cell per cycle carrying the best entry so far;
//   then a shift state moves the later cells left to close the gap, and the
//   response state stages the result after that.
//   Only one request is in work at a time.
// Reset: all cells empty, no current task, no result pending.
// Stall: a result waits in the output register while the receiver is not
//   ready; the next result waits inside the block, and no new request is
//   taken until the output register frees up.
`timescale 1ns / 1ps
module priority_task_queue_with_cancel #(
  parameter int QUEUE_DEPTH   = ptq_pkg::DEF_QUEUE_DEPTH,
  parameter int ID_BITS       = ptq_pkg::DEF_ID_BITS,
  parameter int PRIORITY_BITS = ptq_pkg::DEF_PRI_BITS
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ptq_in_if.sink    in_i,
  ptq_out_if.source out_o
);
  import ptq_pkg::*;

  localparam int IDX_W  = $clog2(QUEUE_DEPTH);
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int SIZE_W = $clog2(QUEUE_DEPTH + 2);

  state_e state_q, state_d;

  logic [CNT_W-1:0]         count_q, count_d;
  logic                     cur_valid_q, cur_valid_d;
  logic [ID_BITS-1:0]       cur_id_q, cur_id_d;
  logic                     cur_can_q, cur_can_d;

  // Result waiting for the output register.
  status_e                  res_status_q, res_status_d;
  logic [ID_BITS-1:0]       res_id_q, res_id_d;
  logic [PRIORITY_BITS-1:0] res_pri_q, res_pri_d;
  logic                     res_can_q, res_can_d;

  // Output register.
  logic                     out_valid_q;
  status_e                  out_status_q;
  logic [ID_BITS-1:0]       out_id_q;
  logic [PRIORITY_BITS-1:0] out_pri_q;
  logic                     out_can_q;
  logic [SIZE_W-1:0]        out_size_q;

  logic      in_fire;
  logic      out_load;
  logic      full;
  op_e       op;
  cell_cmd_t cmd;
  logic      scan_start;

  // Chain wiring. vpad[0] is the left of cell 0, vpad[QUEUE_DEPTH+1] the right
  // of the last cell; entry data pads the right end with an empty slot.
  logic [QUEUE_DEPTH+1:0]   vpad;
  logic [ID_BITS-1:0]       id_w   [QUEUE_DEPTH+1];
  logic [PRIORITY_BITS-1:0] pri_w  [QUEUE_DEPTH+1];
  logic                     can_w  [QUEUE_DEPTH+1];

  logic                     sc_tok   [QUEUE_DEPTH+1];
  logic                     sc_found [QUEUE_DEPTH+1];
  logic [ID_BITS-1:0]       sc_id    [QUEUE_DEPTH+1];
  logic [PRIORITY_BITS-1:0] sc_pri   [QUEUE_DEPTH+1];
  logic                     sc_can   [QUEUE_DEPTH+1];
  logic [IDX_W-1:0]         sc_idx   [QUEUE_DEPTH+1];

  assign op       = op_e'(in_i.opcode);
  assign in_fire  = in_i.valid && in_i.ready;
  assign full     = (count_q == CNT_W'(QUEUE_DEPTH));
  assign out_load = (state_q == S_RESP) && (!out_valid_q || out_o.ready);

  assign vpad[0]               = 1'b1;
  assign vpad[QUEUE_DEPTH+1]   = 1'b0;
  assign id_w[QUEUE_DEPTH]     = '0;
  assign pri_w[QUEUE_DEPTH]    = '0;
  assign can_w[QUEUE_DEPTH]    = 1'b0;

  // Head of the search wave: nothing found yet.
  assign sc_tok[0]   = scan_start;
  assign sc_found[0] = 1'b0;
  assign sc_id[0]    = '0;
  assign sc_pri[0]   = '0;
  assign sc_can[0]   = 1'b0;
  assign sc_idx[0]   = '0;

  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    ptq_cell #(
      .QUEUE_DEPTH   (QUEUE_DEPTH),
      .ID_BITS       (ID_BITS),
      .PRIORITY_BITS (PRIORITY_BITS),
      .CELL_IDX      (g)
    ) u_cell (
      .clk_i           (clk_i),
      .rst_ni          (rst_ni),
      .cmd_i           (cmd),
      .task_id_i       (in_i.task_id),
      .task_priority_i (in_i.task_priority),
      .left_valid_i    (vpad[g]),
      .right_valid_i   (vpad[g+2]),
      .right_id_i      (id_w[g+1]),
      .right_pri_i     (pri_w[g+1]),
      .right_can_i     (can_w[g+1]),
      .best_idx_i      (sc_idx[QUEUE_DEPTH]),
      .scan_tok_i      (sc_tok[g]),
      .scan_found_i    (sc_found[g]),
      .scan_id_i       (sc_id[g]),
      .scan_pri_i      (sc_pri[g]),
      .scan_can_i      (sc_can[g]),
      .scan_idx_i      (sc_idx[g]),
      .valid_o         (vpad[g+1]),
      .id_o            (id_w[g]),
      .pri_o           (pri_w[g]),
      .can_o           (can_w[g]),
      .scan_tok_o      (sc_tok[g+1]),
      .scan_found_o    (sc_found[g+1]),
      .scan_id_o       (sc_id[g+1]),
      .scan_pri_o      (sc_pri[g+1]),
      .scan_can_o      (sc_can[g+1]),
      .scan_idx_o      (sc_idx[g+1])
    );
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          if ((op == OP_EXTRACT) && (count_q != '0)) begin
            state_d = S_SCAN;
          end else begin
            state_d = S_RESP;
          end
        end
      end
      S_SCAN: begin
        if (sc_tok[QUEUE_DEPTH]) begin
          state_d = S_SHIFT;
        end
      end
      S_SHIFT: begin
        state_d = S_RESP;
      end
      S_RESP: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign in_i.ready = (state_q == S_IDLE);

  // Commands, queue bookkeeping and result.
  always_comb begin
    cmd          = '0;
    scan_start   = 1'b0;
    count_d      = count_q;
    cur_valid_d  = cur_valid_q;
    cur_id_d     = cur_id_q;
    cur_can_d    = cur_can_q;
    res_status_d = res_status_q;
    res_id_d     = res_id_q;
    res_pri_d    = res_pri_q;
    res_can_d    = res_can_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          res_status_d = ST_OK;
          res_id_d     = '0;
          res_pri_d    = '0;
          res_can_d    = 1'b0;
          unique case (op)
            OP_ADD: begin
              if (full) begin
                res_status_d = ST_FULL;
              end else begin
                cmd.add = 1'b1;
                count_d = count_q + CNT_W'(1);
              end
            end
            OP_CANCEL_ID: begin
              cmd.cancel = 1'b1;
              if (cur_valid_q && (cur_id_q == in_i.task_id)) begin
                cur_can_d = 1'b1;
              end
            end
            OP_CANCEL_ALL: begin
              cmd.clear = 1'b1;
              count_d   = '0;
              if (cur_valid_q) begin
                cur_can_d = 1'b1;
              end
            end
            OP_EXTRACT: begin
              if (count_q == '0) begin
                res_status_d = ST_EMPTY;
                cur_valid_d  = 1'b0;
                cur_id_d     = '0;
                cur_can_d    = 1'b0;
              end else begin
                scan_start = 1'b1;
              end
            end
            OP_FINISH: begin
              cur_valid_d = 1'b0;
              cur_id_d    = '0;
              cur_can_d   = 1'b0;
            end
            default: begin
            end
          endcase
        end
      end
      S_SCAN: begin
      end
      S_SHIFT: begin
        // Winner sits in the tail of the search wave.
        cmd.shift   = 1'b1;
        count_d     = count_q - CNT_W'(1);
        cur_valid_d = 1'b1;
        cur_id_d    = sc_id[QUEUE_DEPTH];
        cur_can_d   = sc_can[QUEUE_DEPTH];
        res_id_d    = sc_id[QUEUE_DEPTH];
        res_pri_d   = sc_pri[QUEUE_DEPTH];
        res_can_d   = sc_can[QUEUE_DEPTH];
      end
      S_RESP: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      cur_valid_q <= 1'b0;
      cur_id_q    <= '0;
      cur_can_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      cur_valid_q <= cur_valid_d;
      cur_id_q    <= cur_id_d;
      cur_can_q   <= cur_can_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_status_q <= res_status_d;
    res_id_q     <= res_id_d;
    res_pri_q    <= res_pri_d;
    res_can_q    <= res_can_d;
    if (out_load) begin
      out_status_q <= res_status_q;
      out_id_q     <= res_id_q;
      out_pri_q    <= res_pri_q;
      out_can_q    <= res_can_q;
      out_size_q   <= SIZE_W'(count_q) + SIZE_W'(cur_valid_q);
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.status        = out_status_q;
  assign out_o.out_id        = out_id_q;
  assign out_o.out_priority  = out_pri_q;
  assign out_o.out_cancelled = out_can_q;
  assign out_o.size_now      = out_size_q;

`ifndef SYNTHESIS
  // Fill count tracks the packed valid cells.
  a_count_matches_cells: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(vpad[QUEUE_DEPTH:1]) == count_q)
    else $error("pending count differs from valid cells");

  // Valid cells stay packed at the head of the chain.
  a_cells_packed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(vpad[QUEUE_DEPTH:1] & ~(vpad[QUEUE_DEPTH:1] >> 1)))
    else $error("valid cells not packed");

  // The search wave always finds an entry before the shift.
  a_scan_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SHIFT) |-> sc_found[QUEUE_DEPTH])
    else $error("extract shift without a found entry");

  // A result is staged only after the output register can take it.
  a_resp_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RESP && !out_load) |=> (state_q == S_RESP))
    else $error("response dropped while output busy");
`endif

endmodule

// File: rtl/ptq_cell.sv
// One queue cell: a pending entry plus one stage of the max-search wave.
`timescale 1ns / 1ps
module ptq_cell #(
  parameter int QUEUE_DEPTH   = ptq_pkg::DEF_QUEUE_DEPTH,
  parameter int ID_BITS       = ptq_pkg::DEF_ID_BITS,
  parameter int PRIORITY_BITS = ptq_pkg::DEF_PRI_BITS,
  parameter int CELL_IDX      = 0
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  ptq_pkg::cell_cmd_t               cmd_i,
  input  logic [ID_BITS-1:0]               task_id_i,
  input  logic [PRIORITY_BITS-1:0]         task_priority_i,
  input  logic                             left_valid_i,
  input  logic                             right_valid_i,
  input  logic [ID_BITS-1:0]               right_id_i,
  input  logic [PRIORITY_BITS-1:0]         right_pri_i,
  input  logic                             right_can_i,
  input  logic [$clog2(QUEUE_DEPTH)-1:0]   best_idx_i,
  input  logic                             scan_tok_i,
  input  logic                             scan_found_i,
  input  logic [ID_BITS-1:0]               scan_id_i,
  input  logic [PRIORITY_BITS-1:0]         scan_pri_i,
  input  logic                             scan_can_i,
  input  logic [$clog2(QUEUE_DEPTH)-1:0]   scan_idx_i,
  output logic                             valid_o,
  output logic [ID_BITS-1:0]               id_o,
  output logic [PRIORITY_BITS-1:0]         pri_o,
  output logic                             can_o,
  output logic                             scan_tok_o,
  output logic                             scan_found_o,
  output logic [ID_BITS-1:0]               scan_id_o,
  output logic [PRIORITY_BITS-1:0]         scan_pri_o,
  output logic                             scan_can_o,
  output logic [$clog2(QUEUE_DEPTH)-1:0]   scan_idx_o
);
  import ptq_pkg::*;

  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

  logic                     valid_q, valid_d;
  logic [ID_BITS-1:0]       id_q, id_d;
  logic [PRIORITY_BITS-1:0] pri_q, pri_d;
  logic                     can_q, can_d;

  logic                     tok_q;
  logic                     found_q, found_d;
  logic [ID_BITS-1:0]       sid_q, sid_d;
  logic [PRIORITY_BITS-1:0] spri_q, spri_d;
  logic                     scan_can_q, scan_can_d;
  logic [IDX_W-1:0]         sidx_q, sidx_d;
  logic                     take_own;

  // Entry update; ops never overlap, so the order here is arbitrary.
  always_comb begin
    valid_d = valid_q;
    id_d    = id_q;
    pri_d   = pri_q;
    can_d   = can_q;
    if (cmd_i.clear) begin
      valid_d = 1'b0;
    end else if (cmd_i.add && !valid_q && left_valid_i) begin
      valid_d = 1'b1;
      id_d    = task_id_i;
      pri_d   = task_priority_i;
      can_d   = 1'b0;
    end else if (cmd_i.cancel && valid_q && (id_q == task_id_i)) begin
      can_d = 1'b1;
    end else if (cmd_i.shift && (MY_IDX >= best_idx_i)) begin
      valid_d = right_valid_i;
      id_d    = right_id_i;
      pri_d   = right_pri_i;
      can_d   = right_can_i;
    end
  end

  // Strict compare keeps the earliest entry on equal priority.
  assign take_own = valid_q && (!scan_found_i || (pri_q > scan_pri_i));

  always_comb begin
    found_d    = found_q;
    sid_d      = sid_q;
    spri_d     = spri_q;
    scan_can_d = scan_can_q;
    sidx_d     = sidx_q;
    if (scan_tok_i) begin
      if (take_own) begin
        found_d    = 1'b1;
        sid_d      = id_q;
        spri_d     = pri_q;
        scan_can_d = can_q;
        sidx_d     = MY_IDX;
      end else begin
        found_d    = scan_found_i;
        sid_d      = scan_id_i;
        spri_d     = scan_pri_i;
        scan_can_d = scan_can_i;
        sidx_d     = scan_idx_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      tok_q   <= 1'b0;
      found_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      tok_q   <= scan_tok_i;
      found_q <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q       <= id_d;
    pri_q      <= pri_d;
    can_q      <= can_d;
    sid_q      <= sid_d;
    spri_q     <= spri_d;
    scan_can_q <= scan_can_d;
    sidx_q     <= sidx_d;
  end

  assign valid_o      = valid_q;
  assign id_o         = id_q;
  assign pri_o        = pri_q;
  assign can_o        = can_q;
  assign scan_tok_o   = tok_q;
  assign scan_found_o = found_q;
  assign scan_id_o    = sid_q;
  assign scan_pri_o   = spri_q;
  assign scan_can_o   = scan_can_q;
  assign scan_idx_o   = sidx_q;

endmodule

// File: test/tb.sv
// Testbench: checks every reply item of the priority task queue against a shadow queue model.
`timescale 1ns / 1ps
module tb;
  import ptq_pkg::*;

  localparam int DEPTH = DEF_QUEUE_DEPTH;
  localparam int IDW   = DEF_ID_BITS;
  localparam int PRW   = DEF_PRI_BITS;
  localparam int SZW   = $clog2(DEF_QUEUE_DEPTH + 2);

  // Opcodes 5..7 are no-ops in the block.
  localparam logic [OPCODE_W-1:0] OP_NOP_LO = 3'd5;
  localparam logic [OPCODE_W-1:0] OP_NOP_HI = 3'd7;

  localparam int HALF_PERIOD    = 10;
  localparam int RANDOM_ITEMS   = 1350;
  localparam int HOLD_SEGMENT   = 12;   // receiver segment that becomes the long hold-off
  localparam int HOLD_CYCLES    = 500;
  localparam int QUIET_LIMIT    = 4000; // cycles with no handshake on either side
  localparam int DRAIN_CYCLES   = 2 * (DEPTH + 3);

  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_BALANCED} mix_e;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [IDW-1:0]      id;
    logic [PRW-1:0]      pri;
    logic                cancelled;
    logic [SZW-1:0]      size;
  } reply_t;

  // Shadow of the queue: pending entries packed in arrival order plus the current slot.
  // Every accepted request is applied here and the reply it must produce is queued.
  class task_queue_mirror;
    logic [IDW-1:0] ent_id  [DEPTH];
    logic [PRW-1:0] ent_pri [DEPTH];
    bit             ent_can [DEPTH];
    int             count;
    bit             cur_valid;
    logic [IDW-1:0] cur_id;
    bit             cur_can;
    reply_t         owed_replies[$];
    int             mismatches;

    function new();
      count      = 0;
      cur_valid  = 0;
      cur_id     = '0;
      cur_can    = 0;
      mismatches = 0;
    endfunction

    function void clear_current();
      cur_valid = 0;
      cur_id    = '0;
      cur_can   = 0;
    endfunction

    function void apply_request(logic [OPCODE_W-1:0] op, logic [IDW-1:0] id,
                                logic [PRW-1:0] pri);
      reply_t r;
      int     best;
      int     i;
      r.status    = ST_OK;
      r.id        = '0;
      r.pri       = '0;
      r.cancelled = 1'b0;
      case (op)
        OP_ADD: begin
          if (count >= DEPTH) begin
            r.status = ST_FULL;
          end else begin
            ent_id[count]  = id;
            ent_pri[count] = pri;
            ent_can[count] = 0;
            count++;
          end
        end
        OP_CANCEL_ID: begin
          if (cur_valid && cur_id == id) cur_can = 1;
          for (i = 0; i < count; i++)
            if (ent_id[i] == id) ent_can[i] = 1;
        end
        OP_CANCEL_ALL: begin
          if (cur_valid) cur_can = 1;
          count = 0;
        end
        OP_EXTRACT: begin
          if (count == 0) begin
            r.status = ST_EMPTY;
            clear_current();
          end else begin
            // strict compare keeps the earliest entry among equal priorities
            best = 0;
            for (i = 1; i < count; i++)
              if (ent_pri[i] > ent_pri[best]) best = i;
            r.id        = ent_id[best];
            r.pri       = ent_pri[best];
            r.cancelled = ent_can[best];
            cur_valid   = 1;
            cur_id      = ent_id[best];
            cur_can     = ent_can[best];
            for (i = best; i + 1 < count; i++) begin
              ent_id[i]  = ent_id[i+1];
              ent_pri[i] = ent_pri[i+1];
              ent_can[i] = ent_can[i+1];
            end
            count--;
          end
        end
        OP_FINISH: clear_current();
        default: ;
      endcase
      r.size = SZW'(count + (cur_valid ? 1 : 0));
      owed_replies.insert(owed_replies.size(), r);
    endfunction

    function void compare_reply(logic [STATUS_W-1:0] st, logic [IDW-1:0] id,
                                logic [PRW-1:0] pri, logic can, logic [SZW-1:0] size);
      reply_t w;
      if (owed_replies.size() == 0) begin
        $error("reply item with no request awaiting it");
        mismatches++;
        return;
      end
      w = owed_replies.pop_front();
      if (st !== w.status) begin
        $error("status: expected %0d, actual %0d", w.status, st);
        mismatches++;
      end
      if (id !== w.id) begin
        $error("out_id: expected %0h, actual %0h", w.id, id);
        mismatches++;
      end
      if (pri !== w.pri) begin
        $error("out_priority: expected %0h, actual %0h", w.pri, pri);
        mismatches++;
      end
      if (can !== w.cancelled) begin
        $error("out_cancelled: expected %0d, actual %0d", w.cancelled, can);
        mismatches++;
      end
      if (size !== w.size) begin
        $error("size_now: expected %0d, actual %0d", w.size, size);
        mismatches++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  ptq_in_if  #(.ID_BITS(IDW), .PRIORITY_BITS(PRW))                  in_ch  ();
  ptq_out_if #(.ID_BITS(IDW), .PRIORITY_BITS(PRW), .SIZE_BITS(SZW)) out_ch ();

  priority_task_queue_with_cancel #(
    .QUEUE_DEPTH  (DEPTH),
    .ID_BITS      (IDW),
    .PRIORITY_BITS(PRW)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  task_queue_mirror mirror;

  always begin
    clk_i = 1'b0;
    #HALF_PERIOD;
    clk_i = 1'b1;
    #HALF_PERIOD;
  end

  // Handshakes are sampled at the edge, before any driver update of that edge lands.
  // A reply can only belong to a request accepted at an earlier edge.
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1) begin
      if (out_ch.valid && out_ch.ready)
        mirror.compare_reply(out_ch.status, out_ch.out_id, out_ch.out_priority,
                             out_ch.out_cancelled, out_ch.size_now);
      if (in_ch.valid && in_ch.ready)
        mirror.apply_request(in_ch.opcode, in_ch.task_id, in_ch.task_priority);
    end
  end

  // Offer one request item and hold it until the block takes it.
  task automatic send_item(input logic [OPCODE_W-1:0] op, input logic [IDW-1:0] id,
                           input logic [PRW-1:0] pri);
    in_ch.valid         <= 1'b1;
    in_ch.opcode        <= op;
    in_ch.task_id       <= id;
    in_ch.task_priority <= pri;
    do @(posedge clk_i); while (in_ch.ready !== 1'b1);
  endtask

  task automatic sender_gap(input int cycles);
    if (cycles > 0) begin
      in_ch.valid <= 1'b0;
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  function automatic logic [OPCODE_W-1:0] pick_opcode(input mix_e mix);
    int w_add, w_cid, w_call, w_ext, w_fin;
    int r;
    case (mix)
      MIX_FILL:  begin w_add = 65; w_cid = 8;  w_call = 1; w_ext = 14; w_fin = 7;  end
      MIX_DRAIN: begin w_add = 20; w_cid = 12; w_call = 2; w_ext = 50; w_fin = 11; end
      default:   begin w_add = 38; w_cid = 15; w_call = 3; w_ext = 30; w_fin = 9;  end
    endcase
    r = $urandom_range(0, 99);
    if (r < w_add) return OP_ADD;
    r -= w_add;
    if (r < w_cid) return OP_CANCEL_ID;
    r -= w_cid;
    if (r < w_call) return OP_CANCEL_ALL;
    r -= w_call;
    if (r < w_ext) return OP_EXTRACT;
    r -= w_ext;
    if (r < w_fin) return OP_FINISH;
    return OPCODE_W'($urandom_range(OP_NOP_LO, OP_NOP_HI));
  endfunction

  // Small ids repeat often so cancels hit several entries; small priorities give ties.
  function automatic logic [IDW-1:0] pick_add_id();
    if ($urandom_range(0, 1) == 0) return IDW'($urandom_range(0, 15));
    return IDW'($urandom_range(0, (1 << IDW) - 1));
  endfunction

  function automatic logic [PRW-1:0] pick_priority();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return PRW'($urandom_range(0, 3));
    if (r == 4) return '0;
    if (r == 5) return '1;
    return PRW'($urandom_range(0, (1 << PRW) - 1));
  endfunction

  // Cancel ids mostly target something that is pending or current.
  function automatic logic [IDW-1:0] pick_cancel_id();
    int r;
    r = $urandom_range(0, 3);
    if (r < 2 && mirror.count > 0) return mirror.ent_id[$urandom_range(0, mirror.count - 1)];
    if (r == 2 && mirror.cur_valid) return mirror.cur_id;
    return pick_add_id();
  endfunction

  task automatic run_directed();
    int i;
    send_item(OP_EXTRACT, '0, '0);      // extract with nothing pending
    send_item(OP_FINISH, '0, '0);       // finish with no current task
    send_item(OP_CANCEL_ID, 16'h5A5A, '0); // cancel with no match
    send_item(OP_NOP_LO, '1, '1);
    send_item(OP_NOP_HI, '0, '0);
    // Fill to the brim: entries 0 and 9 tie at top priority, odd entries share id zero.
    for (i = 0; i < DEPTH; i++) begin
      if (i == 0)
        send_item(OP_ADD, '1, '1);
      else if (i == 9)
        send_item(OP_ADD, '0, '1);
      else if (i % 2 == 1)
        send_item(OP_ADD, '0, PRW'(i % 4));
      else
        send_item(OP_ADD, IDW'(i * 16'h1111), PRW'(i % 4));
    end
    send_item(OP_ADD, 16'h0BAD, '1);    // queue full, dropped
    send_item(OP_CANCEL_ID, '0, '0);    // marks every odd entry
    send_item(OP_EXTRACT, '0, '0);      // earliest of the tie, not cancelled
    send_item(OP_EXTRACT, '0, '0);      // cancelled one, replaces the current task
    send_item(OP_CANCEL_ID, '0, '0);    // hits the current task
    send_item(OP_CANCEL_ALL, '0, '0);   // current marked, pending list emptied
    send_item(OP_EXTRACT, '0, '0);      // empty queue clears the current slot
  endtask

  task automatic run_random();
    int   sent;
    int   mix_left;
    int   burst_left;
    mix_e mix;
    logic [OPCODE_W-1:0] op;
    logic [IDW-1:0]      id;
    logic [PRW-1:0]      pri;
    sent       = 0;
    mix_left   = 0;
    burst_left = 0;
    mix        = MIX_BALANCED;
    while (sent < RANDOM_ITEMS) begin
      if (mix_left == 0) begin
        mix      = mix_e'($urandom_range(0, 2));
        mix_left = $urandom_range(30, 120);
      end
      // bursts of back-to-back items separated by idle gaps of random length
      if (burst_left == 0) begin
        sender_gap(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10));
        burst_left = $urandom_range(1, 24);
      end
      op  = pick_opcode(mix);
      pri = pick_priority();
      id  = (op == OP_CANCEL_ID) ? pick_cancel_id() : pick_add_id();
      send_item(op, id, pri);
      sent++;
      mix_left--;
      burst_left--;
    end
  endtask

  // Receiver: ready follows segments of varying stall patterns; one segment is a long hold-off
  // during which the sender keeps offering and the block backs up onto its input.
  initial begin : sink_side
    int seg;
    int len;
    int mode;
    int k;
    out_ch.ready <= 1'b0;
    while (rst_ni !== 1'b1) @(posedge clk_i);
    seg = 0;
    forever begin
      seg++;
      if (seg == HOLD_SEGMENT) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        mode = $urandom_range(0, 3);
        len  = $urandom_range(8, 80);
        for (k = 0; k < len; k++) begin
          case (mode)
            0:       out_ch.ready <= 1'b1;
            1:       out_ch.ready <= 1'($urandom_range(0, 1));
            2:       out_ch.ready <= ($urandom_range(0, 3) == 0);
            default: out_ch.ready <= k[0];
          endcase
          @(posedge clk_i);
        end
      end
    end
  end

  // Ends the run when no handshake happens on either side for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
          (out_ch.valid === 1'b1 && out_ch.ready === 1'b1))
        quiet = 0;
      else
        quiet++;
    end
    $display("status: fail");
    $finish;
  end

  initial begin : source_side
    mirror = new();
    rst_ni              <= 1'b0;
    in_ch.valid         <= 1'b0;
    in_ch.opcode        <= '0;
    in_ch.task_id       <= '0;
    in_ch.task_priority <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    run_directed();
    run_random();
    in_ch.valid <= 1'b0;

    // wait out every owed reply, then a little longer to catch strays
    while (mirror.owed_replies.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mirror.mismatches == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
